// File: hdl/ukfq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the unique-key FIFO queue.
package ukfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int ENTRY_W     = KEY_W + VAL_W;
    localparam int OCC_W       = 5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [OCC_W-1:0]        occupancy;
        logic                    is_empty;
    } rsp_t;

endpackage

// File: hdl/ukfq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module ukfq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ukfq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the queue: pointers, key scan with one shared comparator, and commit.
module ukfq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  ukfq_pkg::req_t           req_data,
    output logic                     res_valid,
    input  logic                     res_take,
    output ukfq_pkg::rsp_t           res_data,
    output logic                     wr_en,
    output logic [ukfq_pkg::IDX_W-1:0]   wr_addr,
    output logic [ukfq_pkg::ENTRY_W-1:0] wr_data,
    output logic                     rd_en,
    output logic [ukfq_pkg::IDX_W-1:0]   rd_addr,
    input  logic [ukfq_pkg::ENTRY_W-1:0] rd_data
);

    import ukfq_pkg::*;

    state_t                  state_reg, state_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        issued_reg, issued_next;
    logic                    pend_reg, pend_next;
    status_t                 status_reg, status_next;
    logic signed [KEY_W-1:0] okey_reg, okey_next;
    logic signed [VAL_W-1:0] oval_reg, oval_next;

    logic accept;
    logic match;
    logic scan_end;
    logic issue;
    logic is_full;
    logic commit;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] n;
        begin
            if (i == IDX_W'(QUEUE_DEPTH - 1))
            begin
                n = '0;
            end
            else
            begin
                n = i + 1'b1;
            end
            return n;
        end
    endfunction

    assign accept   = req_valid && (state_reg == S_IDLE);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    // The read issued last cycle is compared now, one stored key per cycle.
    assign match    = pend_reg && (rd_data[ENTRY_W-1:VAL_W] == key_reg);
    assign scan_end = (state_reg == S_SCAN) && (match || (issued_reg == count_reg));
    assign issue    = (state_reg == S_SCAN) && !match && (issued_reg != count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (req_data.mode == MODE_DEQ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and memory control.
    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        res_valid = (state_reg == S_DONE);

        commit = (accept && (req_data.mode == MODE_ENQ) && (count_reg == '0))
              || (scan_end && !match && !is_full);

        wr_en   = commit;
        wr_addr = tail_reg;
        if (state_reg == S_IDLE)
        begin
            wr_data = {req_data.key, req_data.value};
        end
        else
        begin
            wr_data = {key_reg, value_reg};
        end

        rd_en = (accept && (req_data.mode == MODE_DEQ) && (count_reg != '0)) || issue;
        if (state_reg == S_IDLE)
        begin
            rd_addr = head_reg;
        end
        else
        begin
            rd_addr = pos_reg;
        end

        res_data.status    = status_reg;
        res_data.out_key   = okey_reg;
        res_data.out_value = oval_reg;
        res_data.occupancy = OCC_W'(count_reg);
        res_data.is_empty  = (count_reg == '0);
    end

    // Datapath next values.
    always_comb
    begin
        key_next    = key_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        issued_next = issued_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        okey_next   = okey_reg;
        oval_next   = oval_reg;

        if (accept)
        begin
            key_next    = req_data.key;
            value_next  = req_data.value;
            pos_next    = head_reg;
            issued_next = '0;
            okey_next   = '0;
            oval_next   = '0;
            if (req_data.mode == MODE_DEQ)
            begin
                status_next = (count_reg == '0) ? ST_EMPTY : ST_OK;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        if (issue)
        begin
            pend_next   = 1'b1;
            pos_next    = next_slot(pos_reg);
            issued_next = issued_reg + 1'b1;
        end

        if (scan_end)
        begin
            if (match)
            begin
                status_next = ST_DUP;
            end
            else if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        if (state_reg == S_READ)
        begin
            okey_next   = rd_data[ENTRY_W-1:VAL_W];
            oval_next   = rd_data[VAL_W-1:0];
            status_next = ST_OK;
            head_next   = next_slot(head_reg);
            count_next  = count_reg - 1'b1;
        end

        if (commit)
        begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        issued_reg  <= issued_next;
        status_reg  <= status_next;
        okey_reg    <= okey_next;
        oval_reg    <= oval_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !is_full)
        else $error("write into a full queue");

    a_read_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue did not decrement the entry count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status_reg == ST_EMPTY)) |-> (count_reg == '0))
        else $error("empty status reported with stored entries");

    a_dup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_end && match) |=> (count_reg == $past(count_reg)))
        else $error("duplicate key changed the entry count");

endmodule

// File: hdl/unique_key_fifo_queue.sv
`timescale 1ns / 1ps
// Top level of the unique-key FIFO queue: sequencer, entry RAM and result register.
//
// Queue of up to QUEUE_DEPTH key and data pairs that refuses a key already stored. Each
// request transfer gives exactly one response transfer. An enqueue compares the stored keys
// one per cycle through the single read port of the entry RAM, and the request side stays
// stalled from each accepted request until its result moves into the output register. An
// enqueue or a dequeue on an empty queue skips the key scan, and a dequeue of a stored pair
// reads the head entry of the RAM first. The response waits in its own register, so the next
// request is taken while the previous response is stalled.
module unique_key_fifo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ukfq_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ukfq_pkg::rsp_t rsp_data
);

    import ukfq_pkg::*;

    logic               res_valid;
    logic               res_take;
    rsp_t               res_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    ukfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ukfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A finished result moves into the output register when it is empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || !rsp_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res_data;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the unique-key FIFO queue with random idling on both sides.
module tb_top;

    import ukfq_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    // Predicted queue contents, kept in arrival order.
    logic [KEY_W-1:0] q_keys   [QUEUE_DEPTH];
    logic [VAL_W-1:0] q_values [QUEUE_DEPTH];
    int               q_head;
    int               q_tail;
    int               q_count;

    rsp_t             expected_rsp_q [$];
    logic [KEY_W-1:0] key_pool [20];

    int fail_count;
    int rsp_count;
    bit quiet_req;
    bit quiet_rsp;
    int hold_request;

    unique_key_fifo_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Work out the response of one accepted request and advance the predicted queue.
    task automatic predict_queue_op(input req_t item);
        rsp_t r;
        int   pos;
        bit   hit;
        r = '0;
        r.status = ST_OK;
        if (item.mode == MODE_ENQ)
        begin
            hit = 1'b0;
            pos = q_head;
            for (int i = 0; i < q_count; i++)
            begin
                if (q_keys[pos] == item.key)
                    hit = 1'b1;
                pos = (pos + 1) % QUEUE_DEPTH;
            end
            // The duplicate check wins over the full check.
            if (hit)
                r.status = ST_DUP;
            else if (q_count >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                q_keys[q_tail]   = item.key;
                q_values[q_tail] = item.value;
                q_tail = (q_tail + 1) % QUEUE_DEPTH;
                q_count++;
            end
        end
        else
        begin
            if (q_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.out_key   = q_keys[q_head];
                r.out_value = q_values[q_head];
                q_head = (q_head + 1) % QUEUE_DEPTH;
                q_count--;
            end
        end
        r.occupancy = OCC_W'(q_count);
        r.is_empty  = (q_count == 0);
        expected_rsp_q.push_back(r);
    endtask

    // Valid stays high from one transfer to the next when there is no gap.
    task automatic send_item(input req_t item);
        int gap;
        gap = quiet_req ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        predict_queue_op(item);
    endtask

    task automatic send_fields(input logic mode, input logic [31:0] k, input logic [31:0] v);
        req_t item;
        item.mode  = mode;
        item.key   = k;
        item.value = v;
        send_item(item);
    endtask

    function automatic req_t make_item(input int enq_pct);
        req_t item;
        item.mode  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        item.key   = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 19)] : $urandom;
        item.value = $urandom;
        return item;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("response %0d: %s expected %h, got %h",
                                   rsp_count, name, want, got));
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (expected_rsp_q.size() == 0)
            note_failure($sformatf("response %0d arrived with none outstanding", rsp_count));
        else
        begin
            want = expected_rsp_q.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_key", want.out_key, got.out_key);
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        end
        rsp_count++;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                check_response(rsp_data);
        end
    end

    // Response side stall pattern; a long hold-off is counted here when requested.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (!quiet_rsp)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_empty_dequeue();
        send_fields(MODE_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill with extreme keys and data, then hit full, duplicate-when-full and a plain duplicate.
    task automatic test_fill_to_full();
        send_fields(MODE_ENQ, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fields(MODE_ENQ, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(MODE_ENQ, 32'h0000_0000, 32'hFFFF_FFFF);
        send_fields(MODE_ENQ, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int i = 0; i < QUEUE_DEPTH - 4; i++)
            send_fields(MODE_ENQ, {4'(i + 1), 28'($urandom)}, $urandom);
        send_fields(MODE_ENQ, 32'h0555_5555, 32'h1234_5678);
        send_fields(MODE_ENQ, 32'hFFFF_FFFF, 32'h1111_1111);
        send_fields(MODE_DEQ, 32'h0, 32'h0);
        send_fields(MODE_DEQ, 32'h0, 32'h0);
        send_fields(MODE_ENQ, 32'h0000_0000, 32'h2222_2222);
    endtask

    // Phases lean toward filling or draining so that full and empty are both reached often.
    task automatic test_random_traffic();
        int enq_pct;
        for (int i = 0; i < 20; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int b = 0; b < 10; b++)
        begin
            case (b % 3)
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int i = 0; i < 60; i++)
                send_item(make_item(enq_pct));
        end
    endtask

    task automatic test_back_to_back();
        quiet_req = 1'b1;
        quiet_rsp = 1'b1;
        for (int i = 0; i < 100; i++)
            send_item(make_item(55));
        quiet_req = 1'b0;
        quiet_rsp = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the request side must stall.
    task automatic test_output_holdoff();
        quiet_req    = 1'b1;
        hold_request = 400;
        for (int i = 0; i < 50; i++)
            send_item(make_item(70));
        quiet_req = 1'b0;
    endtask

    initial
    begin
        fail_count   = 0;
        rsp_count    = 0;
        quiet_req    = 1'b0;
        quiet_rsp    = 1'b0;
        hold_request = 0;
        q_head       = 0;
        q_tail       = 0;
        q_count      = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dequeue();
        test_fill_to_full();
        test_random_traffic();
        test_back_to_back();
        test_output_holdoff();

        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
